// File: hdl/wfmc_pkg.sv
// ----------------------------------------------------------------------------
// wfmc_pkg
// Shared constants for the wall-follow motion controller.
// ----------------------------------------------------------------------------
package wfmc_pkg;

  localparam logic [1:0] MODE_SEARCH   = 2'd0;
  localparam logic [1:0] MODE_APPROACH = 2'd1;
  localparam logic [1:0] MODE_ALIGN    = 2'd2;
  localparam logic [1:0] MODE_FOLLOW   = 2'd3;

  localparam logic [2:0] REG_DESIRED = 3'd0;
  localparam logic [2:0] REG_STOP    = 3'd1;
  localparam logic [2:0] REG_MAXANG  = 3'd2;
  localparam logic [2:0] REG_SAFE    = 3'd3;
  localparam logic [2:0] REG_MAXLIN  = 3'd4;
  localparam logic [2:0] REG_KPD     = 3'd5;
  localparam logic [2:0] REG_KPA     = 3'd6;

  // Operand widths of the serial units
  localparam int MulW = 32;   // multiplier operand width
  localparam int ProdW = 64;  // product width
  localparam int DivW = 48;   // dividend / quotient width
  localparam int DenW = 24;   // divisor width

endpackage

// File: hdl/wfmc_mul.sv
// ----------------------------------------------------------------------------
// wfmc_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wfmc_mul
  import wfmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MulW-1:0]  a,
  input  logic [MulW-1:0]  b,
  output logic             done,
  output logic [ProdW-1:0] prod
);

  logic [ProdW-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [MulW-1:0]  mplier_r, mplier_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  // one partial product per cycle
  always_comb begin
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; mcand_nxt = {{(ProdW-MulW){1'b0}}, a}; mplier_nxt = b;
      cnt_nxt = 6'(MulW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: hdl/wfmc_div.sv
// ----------------------------------------------------------------------------
// wfmc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfmc_div
  import wfmc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DivW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [DivW-1:0] quo
);

  logic [DivW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt, trial;
  logic [DenW-1:0] den_r, den_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    trial = {rem_r[DenW-1:0], q_r[DivW-1]};
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den;
      cnt_nxt = 6'(DivW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit and try a subtract
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;

endmodule

// File: hdl/wall_follow_motion_controller_top.sv
// ----------------------------------------------------------------------------
// wall_follow_motion_controller_top
// Four-mode wall-follow controller with serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel  | signals                       | transfer when
//  ---------+-------------------------------+------------------------------
//  in       | in_valid/in_stall + fields    | in_valid && !in_stall
//  out      | out_valid/out_stall + fields  | out_valid && !out_stall
//  cfg      | APB psel/penable/pwrite/...   | psel&penable&pwrite
//
// Search, approach and align pass through PRE, FIN and OUT for each fix. Follow
// adds three 32-bit multiplies on the shared serial multiplier and one 48-bit
// divide on the serial divider before FIN and OUT. Input is taken
// only while no fix is in work; a waiting result sits in the output register
// and a stalled output holds the next fix back. Reset is synchronous active
// low and restores the configuration, sequencer and mode state; work and data registers are not reset.
module wall_follow_motion_controller_top
  import wfmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        in_front_clearance_mm,
  input  logic [13:0]        in_left_clearance_mm,
  input  logic [13:0]        in_right_clearance_mm,
  input  logic signed [14:0] in_wall_offset_mm,
  input  logic signed [12:0] in_heading_error_mrad,
  input  logic               in_left_wall_seen,
  input  logic               in_right_wall_seen,
  input  logic               in_front_wall_seen,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_forward_mm_s,
  output logic signed [12:0] out_turn_mrad_s,
  output logic [31:0]        out_command_number,
  output logic [1:0]         out_mode_now,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic [3:0] S_IDLE = 4'd0, S_PRE = 4'd1, S_M1 = 4'd2, S_M1W = 4'd3,
                         S_M2 = 4'd4, S_M2W = 4'd5, S_TURN = 4'd6, S_M3 = 4'd7,
                         S_M3W = 4'd8, S_DIV = 4'd9, S_DIVW = 4'd10,
                         S_FIN = 4'd11, S_OUT = 4'd12;

  // ---------------- configuration registers
  logic [13:0] desired_r, stop_r;
  logic [11:0] maxang_r;
  logic [9:0]  safe_r, maxlin_r;
  logic [15:0] kpd_r, kpa_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r <= 14'd500; stop_r <= 14'd300; maxang_r <= 12'd1000;
      safe_r <= 10'd200; maxlin_r <= 10'd300; kpd_r <= 16'd256; kpa_r <= 16'd256;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DESIRED: desired_r <= cfg_pwdata[13:0];
        REG_STOP:    stop_r <= cfg_pwdata[13:0];
        REG_MAXANG:  maxang_r <= cfg_pwdata[11:0];
        REG_SAFE:    safe_r <= cfg_pwdata[9:0];
        REG_MAXLIN:  maxlin_r <= cfg_pwdata[9:0];
        REG_KPD:     kpd_r <= cfg_pwdata[15:0];
        REG_KPA:     kpa_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_DESIRED: cfg_prdata = {18'd0, desired_r};
      REG_STOP:    cfg_prdata = {18'd0, stop_r};
      REG_MAXANG:  cfg_prdata = {20'd0, maxang_r};
      REG_SAFE:    cfg_prdata = {22'd0, safe_r};
      REG_MAXLIN:  cfg_prdata = {22'd0, maxlin_r};
      REG_KPD:     cfg_prdata = {16'd0, kpd_r};
      REG_KPA:     cfg_prdata = {16'd0, kpa_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------- state
  logic [3:0]  st_r, st_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] tmr_r, tmr_nxt;
  logic [9:0]  lastf_r, lastf_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] seq_r, seq_nxt;

  // latched fix
  logic [13:0]        front_r;
  logic signed [14:0] off_r;
  logic signed [12:0] h_r;
  logic               flag_r;
  logic [15:0]        el_r;

  // work registers
  logic [7:0]         dt_r, dt_nxt;
  logic signed [31:0] s_r, s_nxt;        // follow steering sum
  logic signed [14:0] ang_r, ang_nxt;
  logic [10:0]        lin_r, lin_nxt;
  logic [1:0]         fmode_r, fmode_nxt; // mode as computed by rule
  logic [31:0]        tmp_r, tmp_nxt;    // safe*c

  logic [9:0]         of_r;
  logic signed [12:0] ot_r;
  logic [31:0]        on_r;
  logic [1:0]         om_r;
  logic               ov_r, ov_nxt, load_out;

  // serial units
  logic               mul_start, mul_done, div_start, div_done;
  logic [MulW-1:0]    ma, mb;
  logic [ProdW-1:0]   mp;
  logic [DivW-1:0]    dn, dq;
  logic [DenW-1:0]    dd;

  wfmc_mul u_mul (.clk, .rst_n, .start(mul_start), .a(ma), .b(mb),
                  .done(mul_done), .prod(mp));
  wfmc_div u_div (.clk, .rst_n, .start(div_start), .num(dn), .den(dd),
                  .done(div_done), .quo(dq));

  assign in_stall = (st_r != S_IDLE);
  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      front_r <= in_front_clearance_mm; off_r <= in_wall_offset_mm;
      h_r <= in_heading_error_mrad; el_r <= in_elapsed_ms;
      flag_r <= in_left_wall_seen | in_right_wall_seen | in_front_wall_seen;
    end
  end

  // ---------------- combinational helpers
  logic [14:0]        absd;
  logic [12:0]        absh;
  logic signed [16:0] dapp, err;
  logic signed [15:0] h3;
  logic signed [14:0] hq;
  logic [16:0]        tsum;
  logic [15:0]        tcur;
  logic [31:0]        sabs;
  logic [23:0]        mag;
  logic signed [24:0] angr;
  logic [12:0]        maxa2;
  logic [12:0]        tfac;
  logic signed [14:0] cdiff;
  logic [9:0]         cc;
  logic [23:0]        den;
  logic [8:0]         dlt;
  logic [19:0]        lapp;
  logic signed [12:0] lo, hi;
  logic signed [12:0] linc;

  always_comb begin
    absd = off_r[14] ? 15'(-off_r) : 15'(off_r);
    absh = h_r[12] ? 13'(-h_r) : 13'(h_r);
    dapp = $signed({2'b0, absd}) - $signed({3'b0, desired_r});
    err  = $signed({3'b0, desired_r}) - $signed({2'b0, absd});
    h3 = -(16'(h_r) * 16'sd3);
    hq = 15'(h3 / 16'sd2);
    // 2d/5 by reciprocal, exact over the 250..500 range where it is used
    lapp = (20'(dapp[9:0]) * 20'd410) >> 10;
    tcur = (front_r < stop_r) ? 16'd0 : tmr_r;
    tsum = {1'b0, tcur} + {9'd0, dt_r};
    sabs = s_r[31] ? 32'(-s_r) : 32'(s_r);
    mag = 24'((sabs + 32'd128) >> 8);
    angr = s_r[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    maxa2 = {maxang_r, 1'b0};
    tfac = (maxang_r == 12'd0) ? 13'd1
         : maxa2 - (ang_r[14] ? 13'(-ang_r) : 13'(ang_r));
    cdiff = $signed({1'b0, front_r}) - $signed({1'b0, stop_r});
    cc = cdiff[14] ? 10'd0 : (cdiff > 15'sd800 ? 10'd800 : 10'(cdiff));
    den = (maxang_r == 12'd0) ? 24'd800 : 24'(maxa2) * 24'd800;
    // 3*dt/10 by reciprocal, exact for dt up to 200
    dlt = 9'((18'(dt_r) * 18'd615) >> 11);
    lo = $signed({3'b0, lastf_r}) - $signed({4'b0, dlt});
    hi = $signed({3'b0, lastf_r}) + $signed({4'b0, dlt});
    linc = $signed({2'b0, lin_r});
    if (linc < lo) linc = lo;
    if (linc > hi) linc = hi;
  end

  // ---------------- sequencer
  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; tmr_nxt = tmr_r; lastf_nxt = lastf_r;
    seen_nxt = seen_r; seq_nxt = seq_r; dt_nxt = dt_r; s_nxt = s_r;
    ang_nxt = ang_r; lin_nxt = lin_r; fmode_nxt = fmode_r; tmp_nxt = tmp_r;
    mul_start = 1'b0; div_start = 1'b0;
    ma = '0; mb = '0; dn = '0; dd = den;
    load_out = 1'b0; ov_nxt = ov_r && out_stall;
    case (st_r)
      S_IDLE: if (in_acc) begin
        st_nxt = S_PRE;
        dt_nxt = !seen_r ? 8'd50 : (in_elapsed_ms < 16'd10 ? 8'd10 :
                 (in_elapsed_ms > 16'd200 ? 8'd200 : 8'(in_elapsed_ms)));
        seen_nxt = 1'b1;
      end
      S_PRE: begin
        // obstacle override and timer
        tmr_nxt = tsum[16] ? 16'hFFFF : tsum[15:0];
        fmode_nxt = (front_r < stop_r) ? MODE_SEARCH : mode_r;
        lin_nxt = '0; ang_nxt = '0;
        st_nxt = S_FIN;
        case ((front_r < stop_r) ? MODE_SEARCH : mode_r)
          MODE_SEARCH: begin
            ang_nxt = 15'sd450;
            if (flag_r) begin fmode_nxt = MODE_APPROACH; tmr_nxt = '0; end
          end
          MODE_APPROACH: begin
            if (dapp < 17'sd150) begin
              fmode_nxt = MODE_ALIGN; tmr_nxt = '0;
            end else begin
              lin_nxt = (dapp > 17'sd500) ? 11'd200 :
                        (dapp < 17'sd250 ? 11'd100 : 11'(lapp));
              ang_nxt = (hq > 15'sd800) ? 15'sd800 : (hq < -15'sd800 ? -15'sd800 : hq);
            end
          end
          MODE_ALIGN: begin
            if (absh <= 13'd523 || (tsum[16] ? 16'hFFFF : tsum[15:0]) > 16'd10000) begin
              fmode_nxt = MODE_FOLLOW; tmr_nxt = '0;
            end else begin
              lin_nxt = (absh >= 13'd1048) ? 11'd150 : 11'd80;
              ang_nxt = (hq > 15'sd600) ? 15'sd600 : (hq < -15'sd600 ? -15'sd600 : hq);
            end
          end
          default: st_nxt = S_M1;
        endcase
      end
      S_M1: begin
        // kp_distance * |err|
        mul_start = 1'b1;
        ma = {16'd0, kpd_r};
        mb = 32'(err[16] ? 17'(-err) : 17'(err));
        st_nxt = S_M1W;
      end
      S_M1W: if (mul_done) begin
        s_nxt = ((err[16] ^ off_r[14]) && (err != 0)) ? -$signed(mp[31:0])
                                                      : $signed(mp[31:0]);
        st_nxt = S_M2;
      end
      S_M2: begin
        mul_start = 1'b1;
        ma = {16'd0, kpa_r};
        mb = {19'd0, absh};
        st_nxt = S_M2W;
      end
      S_M2W: if (mul_done) begin
        s_nxt = h_r[12] ? s_r - $signed(mp[31:0]) : s_r + $signed(mp[31:0]);
        st_nxt = S_TURN;
      end
      S_TURN: begin
        if (angr > $signed({13'd0, maxang_r})) ang_nxt = $signed({3'b0, maxang_r});
        else if (angr < -$signed({13'd0, maxang_r})) ang_nxt = -$signed({3'b0, maxang_r});
        else ang_nxt = 15'(angr);
        tmp_nxt = 32'(safe_r) * 32'(cc);
        st_nxt = S_M3;
      end
      S_M3: begin
        mul_start = 1'b1;
        ma = tmp_r; mb = {19'd0, tfac};
        st_nxt = S_M3W;
      end
      S_M3W: if (mul_done) st_nxt = S_DIV;
      S_DIV: begin
        div_start = 1'b1;
        dn = mp[DivW-1:0];
        st_nxt = S_DIVW;
      end
      S_DIVW: if (div_done) begin
        lin_nxt = (dq > 48'(maxlin_r)) ? {1'b0, maxlin_r} : 11'(dq);
        if (absd > 15'd2500 || absd < 15'd200) begin
          fmode_nxt = MODE_SEARCH; tmr_nxt = '0;
        end
        st_nxt = S_FIN;
      end
      S_FIN: begin
        // slew limit and commit
        lastf_nxt = 10'(linc);
        mode_nxt = fmode_r;
        seq_nxt = seq_r + 32'd1;
        st_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || !out_stall) begin
        load_out = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; mode_r <= MODE_SEARCH; tmr_r <= '0; lastf_r <= '0;
      seen_r <= 1'b0; seq_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; tmr_r <= tmr_nxt; lastf_r <= lastf_nxt;
      seen_r <= seen_nxt; seq_r <= seq_nxt; ov_r <= ov_nxt;
    end
    dt_r <= dt_nxt; s_r <= s_nxt; ang_r <= ang_nxt; lin_r <= lin_nxt;
    fmode_r <= fmode_nxt; tmp_r <= tmp_nxt;
    if (load_out) begin
      of_r <= lastf_r; ot_r <= 13'(ang_r); on_r <= seq_r; om_r <= mode_r;
    end
  end

  assign out_valid = ov_r;
  assign out_forward_mm_s = of_r;
  assign out_turn_mrad_s = ot_r;
  assign out_command_number = on_r;
  assign out_mode_now = om_r;

  // ---------------- assertions
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command_number))
    else $error("result changed while stalled");
  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start)) else $error("both units started");
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FIN |=> seq_r == $past(seq_r) + 32'd1)
    else $error("sequence count did not advance");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> in_stall) else $error("input taken while busy");

endmodule
